/* design/dttr_pkg.sv */
// shared types, constants and helpers for the double-to-torus reduction block
// no dependencies
package dttr_pkg;

    // binary64 layout
    localparam int MANT_W   = 52;
    localparam int EXP_W    = 11;
    localparam int SIG_W    = 53;
    localparam int FRAC_BASE = 50;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_DIV   = 2'd0,
        REG_OVH   = 2'd1,
        REG_EXACT = 2'd2
    } t_cfg_idx;

    // control that travels with a magnitude into the packer
    typedef struct packed {
        logic               sgn;
        logic               err;
        logic signed [11:0] k;   // value = mag * 2^k
        logic [5:0]         lz;  // leading zeros of mag in 53 bits
    } t_pack_ctl;

    // leading-zero count of a 53-bit significand, 53 for zero
    function automatic logic [5:0] lzc53(input logic [52:0] v);
        logic [5:0] n;
        n = 6'd53;
        for (int i = 0; i < 53; i++) begin
            if (v[i]) n = 6'(52 - i);
        end
        return n;
    endfunction

endpackage

/* design/double_to_torus_reduce_core.sv */
// top level of the double-to-torus reduction block: six-stage elastic pipeline
// depends on dttr_pkg and dttr_pack
//
// Each binary64 on the input stream is scaled by 2^-log2_divisor and reduced
// modulo 1. Fast mode rounds to 2^-(50-log2_overhead) and folds into [-0.5,0.5);
// exact mode returns y - rint(y) in [-0.5,0.5]. NaN, infinity, overflow and
// fast-mode headroom violations set tuser and return +0. One item is accepted
// per cycle while the output takes results; each passes through input register, unpack,
// shift-round, fraction split, leading-zero count and pack, in that order. Every stage
// holds its own valid bit, so bubbles collapse and input stays open while a
// result waits at the output, so long as some stage is empty. Configuration is to be
// written only while the pipeline is empty; the block itself does not enforce it.
module double_to_torus_reduce_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] x_bits
    input  logic        s_axis_tlast,   // last_in
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] torus_bits
    output logic        m_axis_tuser,   // [0] range_error
    output logic        m_axis_tlast    // last_out
);
    import dttr_pkg::*;

    // configuration registers
    logic signed [10:0] r_div;
    logic [4:0]         r_ovh;
    logic               r_exact;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= 11'sd0;
            r_ovh   <= 5'd0;
            r_exact <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_DIV:   r_div   <= $signed(i_cfg_data);
                REG_OVH:   r_ovh   <= i_cfg_data[4:0];
                REG_EXACT: r_exact <= i_cfg_data[0];
                default:   ;
            endcase
        end
    end

    logic [5:0] f_bits;
    assign f_bits = 6'(FRAC_BASE) - {1'b0, r_ovh};

    // stage valids and request flow
    logic [5:0] r_v;
    logic [5:0] rdy;

    assign rdy[5] = !r_v[5] || m_axis_tready;
    assign rdy[4] = !r_v[4] || rdy[5];
    assign rdy[3] = !r_v[3] || rdy[4];
    assign rdy[2] = !r_v[2] || rdy[3];
    assign rdy[1] = !r_v[1] || rdy[2];
    assign rdy[0] = !r_v[0] || rdy[1];

    assign s_axis_tready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 6'd0;
        end else begin
            if (rdy[0]) r_v[0] <= s_axis_tvalid;
            if (rdy[1]) r_v[1] <= r_v[0];
            if (rdy[2]) r_v[2] <= r_v[1];
            if (rdy[3]) r_v[3] <= r_v[2];
            if (rdy[4]) r_v[4] <= r_v[3];
            if (rdy[5]) r_v[5] <= r_v[4];
        end
    end

    // stage 0: input register
    logic [63:0] r_x;
    logic [5:0]  r_last;

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_x       <= s_axis_tdata;
            r_last[0] <= s_axis_tlast;
        end
        if (rdy[1]) r_last[1] <= r_last[0];
        if (rdy[2]) r_last[2] <= r_last[1];
        if (rdy[3]) r_last[3] <= r_last[2];
        if (rdy[4]) r_last[4] <= r_last[3];
        if (rdy[5]) r_last[5] <= r_last[4];
    end

    // stage 1: unpack, shift amounts and early error checks
    logic               u_sgn;
    logic [10:0]        u_e;
    logic [52:0]        u_m;
    logic [10:0]        u_eb;
    logic [5:0]         u_lz;
    logic signed [14:0] u_eb_s;
    logic signed [14:0] u_d_s;
    logic signed [14:0] u_sh;
    logic signed [14:0] u_k1;
    logic signed [14:0] u_rs;
    logic               n_err1;
    logic [5:0]         n_amt1;
    logic [5:0]         n_lsh1;
    logic signed [11:0] n_k1;

    assign u_sgn  = r_x[63];
    assign u_e    = r_x[62:52];
    assign u_m    = {u_e != 11'd0, r_x[51:0]};
    assign u_eb   = (u_e == 11'd0) ? 11'd1 : u_e;
    assign u_lz   = lzc53(u_m);
    assign u_eb_s = $signed({4'd0, u_eb});
    assign u_d_s  = 15'(r_div);
    assign u_sh   = u_eb_s - 15'sd1075 + $signed({9'd0, f_bits}) - u_d_s;
    assign u_k1   = u_eb_s - 15'sd1075 - $signed({9'd0, u_lz}) - u_d_s;
    assign u_rs   = -15'sd1074 - u_k1;

    always_comb begin
        n_err1 = (u_e == 11'h7FF);
        n_amt1 = 6'd0;
        n_lsh1 = 6'd0;
        n_k1   = 12'sd0;
        if (r_exact) begin
            n_lsh1 = u_lz;
            if (u_m != 53'd0 && u_k1 > 15'sd971) n_err1 = 1'b1;
            if (u_k1 < -15'sd1074) begin
                n_k1   = -12'sd1074;
                n_amt1 = (u_rs > 15'sd63) ? 6'd63 : u_rs[5:0];
            end else begin
                n_k1 = u_k1[11:0];
            end
        end else begin
            if (u_m != 53'd0 && u_sh >= 15'sd0) n_err1 = 1'b1;
            n_amt1 = (-u_sh > 15'sd63) ? 6'd63 : 6'(-u_sh);
        end
    end

    logic               r_sgn1;
    logic               r_err1;
    logic [52:0]        r_m1;
    logic [5:0]         r_amt1;
    logic [5:0]         r_lsh1;
    logic signed [11:0] r_k1;

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_sgn1 <= u_sgn;
            r_err1 <= n_err1;
            r_m1   <= u_m;
            r_amt1 <= n_amt1;
            r_lsh1 <= n_lsh1;
            r_k1   <= n_k1;
        end
    end

    // stage 2: normalize and round half-even at the shift point
    logic [52:0] s_mv;
    logic [63:0] s_mx;
    logic [63:0] s_rem;
    logic [63:0] s_half;
    logic [52:0] s_q;
    logic [52:0] n_q2;

    assign s_mv   = r_m1 << r_lsh1;
    assign s_mx   = {11'd0, s_mv};
    assign s_q    = s_mv >> r_amt1;
    assign s_rem  = s_mx & ((64'd1 << r_amt1) - 64'd1);
    assign s_half = (r_amt1 == 6'd0) ? 64'd0 : (64'd1 << (r_amt1 - 6'd1));

    always_comb begin
        n_q2 = s_q;
        if (r_amt1 != 6'd0 && (s_rem > s_half || (s_rem == s_half && s_q[0]))) begin
            n_q2 = s_q + 53'd1;
        end
    end

    logic               r_sgn2;
    logic               r_err2;
    logic [52:0]        r_q2;
    logic signed [11:0] r_k2;

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_sgn2 <= r_sgn1;
            r_err2 <= r_err1;
            r_q2   <= n_q2;
            r_k2   <= r_k1;
        end
    end

    // stage 3: split off the fraction around the nearest integer
    logic [54:0]        t_qx;
    logic [54:0]        t_sq;
    logic signed [54:0] t_chk;
    logic [54:0]        t_w;
    logic [54:0]        t_pf;
    logic [5:0]         t_nc;
    logic [54:0]        t_pn;
    logic [54:0]        t_fr;
    logic [54:0]        t_hn;
    logic               t_up;
    logic [54:0]        n_g3;
    logic               n_sgn3;
    logic               n_err3;
    logic signed [11:0] n_k3;

    localparam logic signed [54:0] LIM = 55'sd2251799813685248;

    assign t_qx  = {2'd0, r_q2};
    assign t_sq  = r_sgn2 ? (55'd0 - t_qx) : t_qx;
    assign t_pf  = 55'd1 << f_bits;
    assign t_chk = $signed(t_sq + (55'd1 << (f_bits - 6'd1)));
    assign t_w   = t_sq & (t_pf - 55'd1);
    assign t_nc  = (r_k2 >= 12'sd0) ? 6'd0 :
                   ((-r_k2 > 12'sd54) ? 6'd54 : 6'(-r_k2));
    assign t_pn  = 55'd1 << t_nc;
    assign t_fr  = t_qx & (t_pn - 55'd1);
    assign t_hn  = (t_nc == 6'd0) ? 55'd0 : (55'd1 << (t_nc - 6'd1));
    assign t_up  = (t_fr > t_hn) || (t_fr == t_hn && t_qx[t_nc]);

    always_comb begin
        n_err3 = r_err2;
        n_sgn3 = 1'b0;
        n_g3   = 55'd0;
        n_k3   = r_k2;
        if (r_exact) begin
            if (r_k2 < 12'sd0) begin
                n_g3   = t_up ? (t_pn - t_fr) : t_fr;
                n_sgn3 = r_sgn2 ^ t_up;
            end
        end else begin
            if (t_chk < -LIM || t_chk >= LIM) n_err3 = 1'b1;
            n_k3 = -$signed({6'd0, f_bits});
            if (t_w[f_bits - 6'd1]) begin
                n_g3   = t_pf - t_w;
                n_sgn3 = 1'b1;
            end else begin
                n_g3 = t_w;
            end
        end
    end

    logic               r_sgn3;
    logic               r_err3;
    logic [52:0]        r_g3;
    logic signed [11:0] r_k3;

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_sgn3 <= n_sgn3;
            r_err3 <= n_err3;
            r_g3   <= n_g3[52:0];
            r_k3   <= n_k3;
        end
    end

    // stage 4: leading-zero count of the magnitude
    t_pack_ctl   r_ctl4;
    logic [52:0] r_g4;

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_ctl4.sgn <= r_sgn3;
            r_ctl4.err <= r_err3;
            r_ctl4.k   <= r_k3;
            r_ctl4.lz  <= lzc53(r_g3);
            r_g4       <= r_g3;
        end
    end

    // stage 5: pack into the output register
    logic [63:0] n_bits;
    logic [63:0] r_bits;
    logic        r_err5;

    dttr_pack u_pack (
        .i_ctl  (r_ctl4),
        .i_mag  (r_g4),
        .o_bits (n_bits)
    );

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_bits <= n_bits;
            r_err5 <= r_ctl4.err;
        end
    end

    assign m_axis_tvalid = r_v[5];
    assign m_axis_tdata  = r_bits;
    assign m_axis_tuser  = r_err5;
    assign m_axis_tlast  = r_last[5];

endmodule

/* design/dttr_pack.sv */
// packs a signed magnitude and power-of-two scale into a binary64 pattern
// depends on dttr_pkg
module dttr_pack (
    input  dttr_pkg::t_pack_ctl i_ctl,
    input  logic [52:0]         i_mag,
    output logic [63:0]         o_bits
);
    import dttr_pkg::*;

    logic signed [13:0] biased;
    logic signed [13:0] sub_sh;
    logic [52:0]        norm;
    logic [52:0]        subn;

    // biased exponent of the leading one
    assign biased = 14'sd1075 + 14'(i_ctl.k) - $signed({8'd0, i_ctl.lz});
    assign sub_sh = 14'(i_ctl.k) + 14'sd1074;
    assign norm   = i_mag << i_ctl.lz;
    assign subn   = i_mag << sub_sh[5:0];

    // normal, subnormal or zero encoding
    always_comb begin
        if (i_ctl.err || i_mag == 53'd0) begin
            o_bits = 64'd0;
        end else if (biased > 14'sd0) begin
            o_bits = {i_ctl.sgn, biased[10:0], norm[51:0]};
        end else begin
            o_bits = {i_ctl.sgn, 11'd0, subn[51:0]};
        end
    end

endmodule
